// ===== design/page_framebuffer_pixel_plot_core_defines.svh =====
// assertion macros used by the checker file
`ifndef PAGE_FRAMEBUFFER_PIXEL_PLOT_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_PIXEL_PLOT_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PFB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pixel plot check failed");

// next-cycle implication, disabled while in reset
`define PFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pixel plot check failed");

`endif

// ===== design/pfb_plot_pkg.sv =====
package pfb_plot_pkg;

  // display geometry
  localparam int COLUMNS_PER_HALF = 64;
  localparam int PAGES            = 8;
  localparam int ROWS_PER_PAGE    = 8;

  // field widths of the transactions
  localparam int POS_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int PAGE_OW = 3;
  localparam int COL_OW  = 6;

  // internal address layout: {half, page, column}
  localparam int COL_W   = $clog2(COLUMNS_PER_HALF);
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BIT_W   = $clog2(ROWS_PER_PAGE);
  localparam int ADDR_W  = 1 + PAGE_W + COL_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // range limits, one-based
  localparam int CMP_W = 16;
  localparam logic [CMP_W-1:0] X_MAX = CMP_W'(2 * COLUMNS_PER_HALF);
  localparam logic [CMP_W-1:0] Y_MAX = CMP_W'(ROWS_PER_PAGE * PAGES);
  localparam logic [CMP_W-1:0] X_HALF = CMP_W'(COLUMNS_PER_HALF);

  typedef struct packed {
    logic              valid;
    logic              half;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] mask;
    logic [ADDR_W-1:0] addr;
  } decode_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] addr;
  } clear_t;

endpackage

// ===== design/pfb_plot_ram.sv =====
module pfb_plot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read of the address being written returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pfb_plot_decode.sv =====
module pfb_plot_decode (
  input  logic                             valid_i,
  input  logic [pfb_plot_pkg::POS_W-1:0]   pos_x_i,
  input  logic [pfb_plot_pkg::POS_W-1:0]   pos_y_i,
  output pfb_plot_pkg::decode_t            dec_o
);

  logic [pfb_plot_pkg::CMP_W-1:0] x_w;
  logic [pfb_plot_pkg::CMP_W-1:0] y_w;
  logic [pfb_plot_pkg::CMP_W-1:0] col_w;
  logic [pfb_plot_pkg::POS_W-1:0] ym1;
  logic                           x_ok;
  logic                           y_ok;
  logic                           half;

  always_comb begin
    x_w   = pfb_plot_pkg::CMP_W'(pos_x_i);
    y_w   = pfb_plot_pkg::CMP_W'(pos_y_i);
    x_ok  = (x_w != '0) && (x_w <= pfb_plot_pkg::X_MAX);
    y_ok  = (y_w != '0) && (y_w <= pfb_plot_pkg::Y_MAX);
    half  = x_w > pfb_plot_pkg::X_HALF;
    col_w = half ? (x_w - pfb_plot_pkg::X_HALF - pfb_plot_pkg::CMP_W'(1))
                 : (x_w - pfb_plot_pkg::CMP_W'(1));
    ym1   = pos_y_i - pfb_plot_pkg::POS_W'(1);

    dec_o.valid = valid_i && x_ok && y_ok;
    dec_o.half  = half;
    dec_o.page  = pfb_plot_pkg::PAGE_W'(ym1 >> pfb_plot_pkg::BIT_W);
    dec_o.col   = col_w[pfb_plot_pkg::COL_W-1:0];
    dec_o.mask  = pfb_plot_pkg::BYTE_W'(1) << ym1[pfb_plot_pkg::BIT_W-1:0];
    dec_o.addr  = {half, dec_o.page, dec_o.col};
  end

endmodule

// ===== design/pfb_plot_clear.sv =====
module pfb_plot_clear (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  output pfb_plot_pkg::clear_t  clr_o
);

  logic                              busy_q;
  logic                              busy_d;
  logic [pfb_plot_pkg::ADDR_W-1:0]   cnt_q;
  logic [pfb_plot_pkg::ADDR_W-1:0]   cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + pfb_plot_pkg::ADDR_W'(1);
      if (cnt_q == pfb_plot_pkg::ADDR_W'(pfb_plot_pkg::MEM_DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign clr_o.busy = busy_q;
  assign clr_o.addr = cnt_q;

endmodule

// ===== design/page_framebuffer_pixel_plot_core.sv =====
// channel | direction | handshake             | payload
// in      | sink      | in_valid_i/in_stall_o   | pos_x_i, pos_y_i, turn_on_i
// out     | source    | out_valid_o/out_stall_i | half_select_o, page_index_o,
//         |           |                         | column_index_o, new_byte_o
//
// one transaction per cycle sustained once the clearing pass is done and while
// out_stall_i does not freeze the pipe; a taken request passes the input reg,
// the ram read reg and the result reg in that order before it is on the output
// after reset a clearing pass writes zero to all 1024 display bytes, one per
// cycle; in_stall_o is high until that pass is done
// the whole pipeline moves together: out_stall_i on a full result register
// freezes every stage and raises in_stall_o
// out-of-range requests travel as bubbles and give no result
module page_framebuffer_pixel_plot_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pfb_plot_pkg::POS_W-1:0]      pos_x_i,
  input  logic [pfb_plot_pkg::POS_W-1:0]      pos_y_i,
  input  logic                                turn_on_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                half_select_o,
  output logic [pfb_plot_pkg::PAGE_OW-1:0]    page_index_o,
  output logic [pfb_plot_pkg::COL_OW-1:0]     column_index_o,
  output logic [pfb_plot_pkg::BYTE_W-1:0]     new_byte_o
);

  // pipeline advance: result register empty or being taken
  logic                              adv;
  pfb_plot_pkg::clear_t              clr;
  pfb_plot_pkg::decode_t             dec;

  // stage 1: registered request
  logic                              s1_valid_q;
  logic [pfb_plot_pkg::POS_W-1:0]    s1_x_q;
  logic [pfb_plot_pkg::POS_W-1:0]    s1_y_q;
  logic                              s1_on_q;

  // stage 2: decoded request, ram data arrives here
  logic                              s2_valid_q;
  logic                              s2_on_q;
  logic                              s2_half_q;
  logic [pfb_plot_pkg::PAGE_W-1:0]   s2_page_q;
  logic [pfb_plot_pkg::COL_W-1:0]    s2_col_q;
  logic [pfb_plot_pkg::BYTE_W-1:0]   s2_mask_q;
  logic [pfb_plot_pkg::ADDR_W-1:0]   s2_addr_q;

  // last write, covers the read that raced it
  logic                              fwd_valid_q;
  logic [pfb_plot_pkg::ADDR_W-1:0]   fwd_addr_q;
  logic [pfb_plot_pkg::BYTE_W-1:0]   fwd_data_q;

  // result register
  logic                              out_valid_q;
  logic                              out_half_q;
  logic [pfb_plot_pkg::PAGE_OW-1:0]  out_page_q;
  logic [pfb_plot_pkg::COL_OW-1:0]   out_col_q;
  logic [pfb_plot_pkg::BYTE_W-1:0]   out_byte_q;

  logic [pfb_plot_pkg::BYTE_W-1:0]   ram_rdata;
  logic [pfb_plot_pkg::BYTE_W-1:0]   cur_byte;
  logic [pfb_plot_pkg::BYTE_W-1:0]   new_byte_d;
  logic                              ram_we;
  logic [pfb_plot_pkg::ADDR_W-1:0]   ram_waddr;
  logic [pfb_plot_pkg::BYTE_W-1:0]   ram_wdata;
  logic [pfb_plot_pkg::ADDR_W-1:0]   ram_raddr;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = clr.busy || !adv;

  pfb_plot_clear u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_o  (clr)
  );

  pfb_plot_decode u_decode (
    .valid_i (s1_valid_q),
    .pos_x_i (s1_x_q),
    .pos_y_i (s1_y_q),
    .dec_o   (dec)
  );

  // the write that happens while a read of the same byte is in flight is
  // not seen by that read, so take the forwarded copy instead
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s2_addr_q)) begin
      cur_byte = fwd_data_q;
    end else begin
      cur_byte = ram_rdata;
    end
    if (s2_on_q) begin
      new_byte_d = cur_byte | s2_mask_q;
    end else begin
      new_byte_d = cur_byte & ~s2_mask_q;
    end
  end

  // clearing pass owns the write port until it is done
  always_comb begin
    if (clr.busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr.addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_valid_q && adv;
      ram_waddr = s2_addr_q;
      ram_wdata = new_byte_d;
    end
  end

  // read address follows stage 1 while the pipe moves; while frozen it
  // rereads the stage 2 byte, which by then holds every earlier write
  assign ram_raddr = adv ? dec.addr : s2_addr_q;

  pfb_plot_ram #(
    .WIDTH (pfb_plot_pkg::BYTE_W),
    .DEPTH (pfb_plot_pkg::MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i && !clr.busy;
      s2_valid_q  <= dec.valid;
      fwd_valid_q <= s2_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i && !clr.busy) begin
        s1_x_q  <= pos_x_i;
        s1_y_q  <= pos_y_i;
        s1_on_q <= turn_on_i;
      end
      s2_on_q    <= s1_on_q;
      s2_half_q  <= dec.half;
      s2_page_q  <= dec.page;
      s2_col_q   <= dec.col;
      s2_mask_q  <= dec.mask;
      s2_addr_q  <= dec.addr;
      fwd_addr_q <= s2_addr_q;
      fwd_data_q <= new_byte_d;
      out_half_q <= s2_half_q;
      out_page_q <= pfb_plot_pkg::PAGE_OW'(s2_page_q);
      out_col_q  <= pfb_plot_pkg::COL_OW'(s2_col_q);
      out_byte_q <= new_byte_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign half_select_o  = out_half_q;
  assign page_index_o   = out_page_q;
  assign column_index_o = out_col_q;
  assign new_byte_o     = out_byte_q;

endmodule

// ===== design/pfb_plot_checker.sv =====
`include "page_framebuffer_pixel_plot_core_defines.svh"

module pfb_plot_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [pfb_plot_pkg::POS_W-1:0]    pos_x_i,
  input logic [pfb_plot_pkg::POS_W-1:0]    pos_y_i,
  input logic                              turn_on_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic                              half_select_o,
  input logic [pfb_plot_pkg::PAGE_OW-1:0]  page_index_o,
  input logic [pfb_plot_pkg::COL_OW-1:0]   column_index_o,
  input logic [pfb_plot_pkg::BYTE_W-1:0]   new_byte_o
);

  logic out_block;
  logic in_take;
  logic tl_set;
  logic tl_seen;
  logic br_clr;
  logic br_seen;

  assign out_block = out_valid_o && out_stall_i;
  assign in_take   = in_valid_i && !in_stall_o;
  assign tl_set    = in_take && pos_x_i == 8'd1 && pos_y_i == 8'd1 && turn_on_i;
  assign tl_seen   = out_valid_o && new_byte_o[0] && !half_select_o &&
                     page_index_o == 3'd0 && column_index_o == 6'd0;
  assign br_clr    = in_take && pos_x_i == 8'd128 && pos_y_i == 8'd64 && !turn_on_i;
  assign br_seen   = out_valid_o && !new_byte_o[7] && half_select_o &&
                     page_index_o == 3'd7 && column_index_o == 6'd63;

  // a blocked result holds
  `PFB_ASSERT_NEXT(a_out_hold, out_block, out_valid_o && $stable(new_byte_o) && $stable(column_index_o))

  // a blocked result register backs up into the input side
  `PFB_ASSERT_NOW(a_backpressure, out_block, in_stall_o)

  // top-left pixel set, free-running output: the result shows the bit set
  `PFB_ASSERT_NEXT(a_top_left_set, tl_set ##1 !out_stall_i ##1 !out_stall_i, tl_seen)

  // bottom-right pixel cleared, free-running output
  `PFB_ASSERT_NEXT(a_bot_right_clr, br_clr ##1 !out_stall_i ##1 !out_stall_i, br_seen)

endmodule

bind page_framebuffer_pixel_plot_core pfb_plot_checker u_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
  import pfb_plot_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS   = 800;
  localparam int QUIET_TAIL     = 100;   // last items run with no idling on either side
  localparam int DRAIN_CYCLES   = 12;    // three-stage pipe plus margin
  localparam int WATCHDOG_LIMIT = 4096;  // covers the clearing pass after reset
  localparam int MAX_REPORTS    = 10;
  localparam int SCREEN_BYTES   = 2 * PAGES * COLUMNS_PER_HALF;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    EXP_FROM_MODEL,  // predictor supplies the result
    EXP_TYPED,       // result written into the table
    EXP_DROPPED      // out of range, no result
  } exp_kind_e;

  typedef struct packed {
    logic               half;
    logic [PAGE_OW-1:0] page;
    logic [COL_OW-1:0]  col;
    logic [BYTE_W-1:0]  value;
  } plot_result_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             set_px;
    exp_kind_e        kind;
    plot_result_t     typed;
  } plot_row_t;

  localparam plot_result_t NO_PLOT = '0;

  // directed rows: corners, both halves, page edges, dropped positions and
  // back-to-back hits on one byte that need forwarding in the pipe
  localparam int NUM_DIRECTED = 24;
  plot_row_t directed_rows [NUM_DIRECTED] = '{
    // top-left pixel on a cleared screen
    '{8'd1,   8'd1,   1'b1, EXP_TYPED,   '{1'b0, 3'd0, 6'd0,  8'h01}},
    // bottom-right pixel, right controller, last page and column
    '{8'd128, 8'd64,  1'b1, EXP_TYPED,   '{1'b1, 3'd7, 6'd63, 8'h80}},
    // zero x, zero y, x past the right edge, y past the bottom, all ones
    '{8'd0,   8'd1,   1'b1, EXP_DROPPED, NO_PLOT},
    '{8'd1,   8'd0,   1'b1, EXP_DROPPED, NO_PLOT},
    '{8'd129, 8'd1,   1'b1, EXP_DROPPED, NO_PLOT},
    '{8'd1,   8'd65,  1'b1, EXP_DROPPED, NO_PLOT},
    '{8'd255, 8'd255, 1'b1, EXP_DROPPED, NO_PLOT},
    // last column of the left half, first of the right half
    '{8'd64,  8'd8,   1'b1, EXP_TYPED,   '{1'b0, 3'd0, 6'd63, 8'h80}},
    '{8'd65,  8'd9,   1'b1, EXP_TYPED,   '{1'b1, 3'd1, 6'd0,  8'h01}},
    // same byte hit in a row: set, set, set, clear, clear again
    '{8'd2,   8'd1,   1'b1, EXP_TYPED,   '{1'b0, 3'd0, 6'd1,  8'h01}},
    '{8'd2,   8'd2,   1'b1, EXP_TYPED,   '{1'b0, 3'd0, 6'd1,  8'h03}},
    '{8'd2,   8'd3,   1'b1, EXP_TYPED,   '{1'b0, 3'd0, 6'd1,  8'h07}},
    '{8'd2,   8'd2,   1'b0, EXP_TYPED,   '{1'b0, 3'd0, 6'd1,  8'h05}},
    '{8'd2,   8'd2,   1'b0, EXP_TYPED,   '{1'b0, 3'd0, 6'd1,  8'h05}},
    // clear the corners again
    '{8'd1,   8'd1,   1'b0, EXP_TYPED,   '{1'b0, 3'd0, 6'd0,  8'h00}},
    '{8'd128, 8'd64,  1'b0, EXP_TYPED,   '{1'b1, 3'd7, 6'd63, 8'h00}},
    // mid-screen pixels, three sharing a byte, left to the predictor
    '{8'd100, 8'd37,  1'b1, EXP_FROM_MODEL, NO_PLOT},
    '{8'd100, 8'd40,  1'b1, EXP_FROM_MODEL, NO_PLOT},
    '{8'd100, 8'd33,  1'b1, EXP_FROM_MODEL, NO_PLOT},
    '{8'd33,  8'd17,  1'b0, EXP_FROM_MODEL, NO_PLOT},
    // alternating bit patterns outside the screen
    '{8'd170, 8'd30,  1'b1, EXP_DROPPED, NO_PLOT},
    '{8'd85,  8'd85,  1'b1, EXP_DROPPED, NO_PLOT},
    // bottom row of the left half, top row of the right half
    '{8'd64,  8'd64,  1'b1, EXP_TYPED,   '{1'b0, 3'd7, 6'd63, 8'h80}},
    '{8'd65,  8'd1,   1'b1, EXP_TYPED,   '{1'b1, 3'd0, 6'd0,  8'h01}}
  };

  // clock, reset and block ports; the driven ones are known from time zero
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [POS_W-1:0]     pos_x_i = '0;
  logic [POS_W-1:0]     pos_y_i = '0;
  logic                 turn_on_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 half_select_o;
  logic [PAGE_OW-1:0]   page_index_o;
  logic [COL_OW-1:0]    column_index_o;
  logic [BYTE_W-1:0]    new_byte_o;

  // how the transaction now on the input is to be checked
  exp_kind_e            row_kind = EXP_FROM_MODEL;
  plot_result_t         row_typed = NO_PLOT;

  // shared test state
  logic                 quiet_tail = 1'b0;
  int                   idle_pct = 0;
  int                   failures = 0;
  int                   quiet_cycles = 0;
  plot_result_t         expected_plots [$];
  logic [BYTE_W-1:0]    shadow_screen [SCREEN_BYTES];

  always #4 clk_i = ~clk_i;

  page_framebuffer_pixel_plot_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .turn_on_i      (turn_on_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .half_select_o  (half_select_o),
    .page_index_o   (page_index_o),
    .column_index_o (column_index_o),
    .new_byte_o     (new_byte_o)
  );

  // only the first few failures are printed, all are counted
  task automatic log_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("%s", msg);
  endtask

  // read-modify-write of one pixel on the shadow screen; returns 0 when the
  // position is off screen and nothing is plotted
  function automatic bit plot_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                    input logic set_px, output plot_result_t res);
    int                xi, yi, half, col, page, addr;
    logic [BYTE_W-1:0] mask;
    xi  = x;
    yi  = y;
    res = NO_PLOT;
    if (xi == 0 || xi > 2 * COLUMNS_PER_HALF) return 1'b0;
    if (yi == 0 || yi > ROWS_PER_PAGE * PAGES) return 1'b0;
    half = (xi > COLUMNS_PER_HALF) ? 1 : 0;
    col  = xi - half * COLUMNS_PER_HALF - 1;
    page = (yi - 1) / ROWS_PER_PAGE;
    mask = BYTE_W'(1) << ((yi - 1) % ROWS_PER_PAGE);
    addr = (half * PAGES + page) * COLUMNS_PER_HALF + col;
    if (set_px) shadow_screen[addr] = shadow_screen[addr] | mask;
    else        shadow_screen[addr] = shadow_screen[addr] & ~mask;
    res.half  = half[0];
    res.page  = PAGE_OW'(page);
    res.col   = COL_OW'(col);
    res.value = shadow_screen[addr];
    return 1'b1;
  endfunction

  // present one request and hold it until the block takes it; an optional
  // idle burst goes first
  task automatic offer_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                             input logic set_px, input exp_kind_e kind,
                             input plot_result_t typed);
    int gap;
    if (!quiet_tail && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(7, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    turn_on_i  <= set_px;
    row_kind   <= kind;
    row_typed  <= typed;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // result checking first, then prediction of the transaction taken at this
  // edge; both in one process so the queue order never depends on the
  // scheduler
  always @(posedge clk_i) begin : result_check
    plot_result_t got, want, modeled;
    bit           hit;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{half_select_o, page_index_o, column_index_o, new_byte_o};
        if (expected_plots.size() == 0) begin
          log_failure($sformatf("unexpected result: half %0d page %0d col %0d byte %02h",
                                got.half, got.page, got.col, got.value));
        end else begin
          want = expected_plots.pop_front();
          if (got.half !== want.half || got.page !== want.page ||
              got.col !== want.col || got.value !== want.value) begin
            log_failure($sformatf(
              "mismatch: expected half %0d page %0d col %0d byte %02h, got half %0d page %0d col %0d byte %02h",
              want.half, want.page, want.col, want.value,
              got.half, got.page, got.col, got.value));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        // the predictor always runs so the shadow screen tracks every write
        hit = plot_pixel(pos_x_i, pos_y_i, turn_on_i, modeled);
        if (row_kind == EXP_TYPED) expected_plots.push_back(row_typed);
        else if (row_kind == EXP_FROM_MODEL && hit) expected_plots.push_back(modeled);
      end
    end
  end

  // receiver stall: random bursts whose density is redrawn among three levels,
  // including stretches with none
  always @(posedge clk_i) begin : receiver_stall
    int stall_left;
    int stall_pct;
    int cycle_no;
    cycle_no++;
    if (cycle_no % 64 == 0) begin
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 15;
        default: stall_pct = 40;
      endcase
    end
    if (stall_left > 0) stall_left--;
    else if (!quiet_tail && $urandom_range(99) < stall_pct) stall_left = $urandom_range(7, 1);
    out_stall_i <= (stall_left > 0);
  end

  // watchdog on cycles where neither channel moves a transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [POS_W-1:0] x, y;
    logic [POS_W-1:0] last_x, last_y;
    logic             set_px;
    int               pick;
    logic [POS_W-1:0] hot_x [4];
    logic [POS_W-1:0] hot_y [4];
    hot_x  = '{8'd1, 8'd64, 8'd65, 8'd128};
    hot_y  = '{8'd1, 8'd8, 8'd57, 8'd64};
    last_x = 8'd1;
    last_y = 8'd1;
    foreach (shadow_screen[a]) shadow_screen[a] = '0;

    // reset once; the block then clears its memory with in_stall_o high
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 30;
    foreach (directed_rows[r]) begin
      offer_pixel(directed_rows[r].x, directed_rows[r].y, directed_rows[r].set_px,
                  directed_rows[r].kind, directed_rows[r].typed);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // sender idle density changes every 50 transactions
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 50;
        endcase
      end
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet_tail <= 1'b1;
      pick   = $urandom_range(99);
      set_px = 1'($urandom_range(1));
      if (pick < 12) begin
        // raw noise over the full field range, mostly off screen
        x = POS_W'($urandom);
        y = POS_W'($urandom);
      end else if (pick < 50) begin
        // another bit of the byte just touched, exercises forwarding
        x = last_x;
        y = POS_W'(((last_y - 1) / ROWS_PER_PAGE) * ROWS_PER_PAGE + $urandom_range(8, 1));
      end else if (pick < 65) begin
        // small set of edge positions that keep getting revisited
        x = hot_x[$urandom_range(3)];
        y = hot_y[$urandom_range(3)];
      end else begin
        x = POS_W'($urandom_range(2 * COLUMNS_PER_HALF, 1));
        y = POS_W'($urandom_range(ROWS_PER_PAGE * PAGES, 1));
      end
      if (x != 0 && x <= 2 * COLUMNS_PER_HALF && y != 0 && y <= ROWS_PER_PAGE * PAGES) begin
        last_x = x;
        last_y = y;
      end
      offer_pixel(x, y, set_px, EXP_FROM_MODEL, NO_PLOT);
    end
    in_valid_i <= 1'b0;

    // drain, then give the pipe time to show any stray result
    while (expected_plots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
